// File: hdl/pibq_pkg.sv
`timescale 1ns / 1ps

package pibq_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int SLOT_W  = 6;
    localparam int FUNC_W  = 2;
    localparam int ERR_W   = 2;

    // position word {x, y}; shape word {centre x, centre y, size x, size y}
    localparam int POS_W   = 2 * COORD_W;
    localparam int SHAPE_W = 2 * COORD_W + 2 * SIZE_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD       = 2'd0,
        FN_SET_POS   = 2'd1,
        FN_QUERY_S   = 2'd2,
        FN_QUERY_ALL = 2'd3
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 2'd0,
        ERR_FULL = 2'd1,
        ERR_SLOT = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic wr_static;
        logic wr_pos;
        logic wr_shape;
        logic scan_valid;
        logic scan_static;
        logic scan_last;
        logic flush;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              res_valid;
        logic              res_hit;
        logic              res_last;
        logic [SLOT_W-1:0] res_slot;
    } stat_t;

    // open-interval test on one axis: |2*d| < s
    function automatic logic axis_in(input logic [COORD_W+1:0] d,
                                     input logic [SIZE_W-1:0]  s);
        logic signed [COORD_W+2:0] twice;
        logic signed [COORD_W+2:0] lim;
        twice = $signed({d, 1'b0});
        lim   = $signed({4'b0000, s});
        return (twice < lim) && (twice > -lim);
    endfunction

endpackage

// File: hdl/pibq_dpath.sv
`timescale 1ns / 1ps

module pibq_dpath #(
    parameter int MAX_BOXES = 64,
    parameter int AW        = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pibq_pkg::cmd_t                      cmd,
    input  logic [AW-1:0]                       wr_addr,
    input  logic [AW-1:0]                       rd_addr,
    input  logic signed [pibq_pkg::COORD_W-1:0] pos_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] pos_y,
    input  logic signed [pibq_pkg::COORD_W-1:0] center_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] center_y,
    input  logic [pibq_pkg::SIZE_W-1:0]         size_x,
    input  logic [pibq_pkg::SIZE_W-1:0]         size_y,
    input  logic signed [pibq_pkg::COORD_W-1:0] point_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] point_y,
    output pibq_pkg::stat_t                     stat
);
    import pibq_pkg::*;

    // transaction payload
    logic [COORD_W-1:0] px_reg, py_reg, cx_reg, cy_reg, ptx_reg, pty_reg;
    logic [SIZE_W-1:0]  sx_reg, sy_reg;

    logic [POS_W-1:0]   s_pos_mem   [MAX_BOXES];
    logic [SHAPE_W-1:0] s_shape_mem [MAX_BOXES];
    logic [POS_W-1:0]   d_pos_mem   [MAX_BOXES];
    logic [SHAPE_W-1:0] d_shape_mem [MAX_BOXES];

    // stage 0: registered memory read
    logic [POS_W-1:0]   rd_s_pos_reg, rd_d_pos_reg;
    logic [SHAPE_W-1:0] rd_s_shape_reg, rd_d_shape_reg;
    logic               v0_reg, st0_reg, last0_reg;
    logic [AW-1:0]      idx0_reg;

    // stage 1: point minus position
    logic [COORD_W:0]   ax1_reg, ay1_reg;
    logic [COORD_W-1:0] cx1_reg, cy1_reg;
    logic [SIZE_W-1:0]  sx1_reg, sy1_reg;
    logic               v1_reg, last1_reg;
    logic [AW-1:0]      idx1_reg;

    // stage 2: minus centre offset
    logic [COORD_W+1:0] dx2_reg, dy2_reg;
    logic [SIZE_W-1:0]  sx2_reg, sy2_reg;
    logic               v2_reg, last2_reg;
    logic [AW-1:0]      idx2_reg;

    // stage 3: containment result
    logic               v3_reg, hit3_reg, last3_reg;
    logic [AW-1:0]      idx3_reg;

    logic [POS_W-1:0]   sel_pos;
    logic [SHAPE_W-1:0] sel_shape;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            sx_reg  <= size_x;
            sy_reg  <= size_y;
            ptx_reg <= point_x;
            pty_reg <= point_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_pos && cmd.wr_static)
            s_pos_mem[wr_addr] <= {px_reg, py_reg};
        if (cmd.wr_shape && cmd.wr_static)
            s_shape_mem[wr_addr] <= {cx_reg, cy_reg, sx_reg, sy_reg};
        if (cmd.wr_pos && !cmd.wr_static)
            d_pos_mem[wr_addr] <= {px_reg, py_reg};
        if (cmd.wr_shape && !cmd.wr_static)
            d_shape_mem[wr_addr] <= {cx_reg, cy_reg, sx_reg, sy_reg};
        rd_s_pos_reg   <= s_pos_mem[rd_addr];
        rd_s_shape_reg <= s_shape_mem[rd_addr];
        rd_d_pos_reg   <= d_pos_mem[rd_addr];
        rd_d_shape_reg <= d_shape_mem[rd_addr];
    end

    always_comb
    begin
        sel_pos   = st0_reg ? rd_s_pos_reg : rd_d_pos_reg;
        sel_shape = st0_reg ? rd_s_shape_reg : rd_d_shape_reg;
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        st0_reg   <= cmd.scan_static;
        last0_reg <= cmd.scan_last;
        idx0_reg  <= rd_addr;

        ax1_reg   <= {ptx_reg[COORD_W-1], ptx_reg}
                   - {sel_pos[POS_W-1], sel_pos[POS_W-1 -: COORD_W]};
        ay1_reg   <= {pty_reg[COORD_W-1], pty_reg}
                   - {sel_pos[COORD_W-1], sel_pos[COORD_W-1:0]};
        cx1_reg   <= sel_shape[SHAPE_W-1 -: COORD_W];
        cy1_reg   <= sel_shape[SHAPE_W-COORD_W-1 -: COORD_W];
        sx1_reg   <= sel_shape[2*SIZE_W-1 -: SIZE_W];
        sy1_reg   <= sel_shape[SIZE_W-1:0];
        last1_reg <= last0_reg;
        idx1_reg  <= idx0_reg;

        dx2_reg   <= {ax1_reg[COORD_W], ax1_reg}
                   - {{2{cx1_reg[COORD_W-1]}}, cx1_reg};
        dy2_reg   <= {ay1_reg[COORD_W], ay1_reg}
                   - {{2{cy1_reg[COORD_W-1]}}, cy1_reg};
        sx2_reg   <= sx1_reg;
        sy2_reg   <= sy1_reg;
        last2_reg <= last1_reg;
        idx2_reg  <= idx1_reg;

        hit3_reg  <= axis_in(dx2_reg, sx2_reg) && axis_in(dy2_reg, sy2_reg);
        last3_reg <= last2_reg;
        idx3_reg  <= idx2_reg;
    end

    // valid bits; flush drops everything still in flight after a hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.scan_valid && !cmd.flush;
            v1_reg <= v0_reg && !cmd.flush;
            v2_reg <= v1_reg && !cmd.flush;
            v3_reg <= v2_reg && !cmd.flush;
        end
    end

    always_comb
    begin
        stat.res_valid = v3_reg;
        stat.res_hit   = hit3_reg;
        stat.res_last  = last3_reg;
        stat.res_slot  = SLOT_W'(idx3_reg);
    end

endmodule

// File: hdl/pibq_ctrl.sv
`timescale 1ns / 1ps

module pibq_ctrl #(
    parameter int MAX_BOXES = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [pibq_pkg::FUNC_W-1:0]        func,
    input  logic                               is_static,
    input  logic [pibq_pkg::SLOT_W-1:0]        entry_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic                               hit_is_static,
    output logic [pibq_pkg::SLOT_W-1:0]        hit_slot,
    output logic [pibq_pkg::SLOT_W-1:0]        new_slot,
    output logic [pibq_pkg::ERR_W-1:0]         error,
    output pibq_pkg::cmd_t                     cmd,
    output logic [AW-1:0]                      wr_addr,
    output logic [AW-1:0]                      rd_addr,
    input  pibq_pkg::stat_t                    stat
);
    import pibq_pkg::*;

    state_t            state_reg, state_next;
    func_t             func_reg;
    logic              static_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [CW-1:0]     s_count_reg, s_count_next;
    logic [CW-1:0]     d_count_reg, d_count_next;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              scan_static_reg, scan_static_next;

    logic              pend_hit_reg, pend_hit_next;
    logic              pend_static_reg, pend_static_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [SLOT_W-1:0] pend_new_reg, pend_new_next;
    err_t              pend_err_reg, pend_err_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_static_reg;
    logic [SLOT_W-1:0] out_slot_reg, out_new_reg;
    err_t              out_err_reg;

    logic              accept;
    logic [CW-1:0]     sel_count;
    logic [CW-1:0]     scan_count;
    logic              full;
    logic              slot_bad;
    logic              res_done;
    logic              to_dynamic;
    logic              out_load;

    always_comb
    begin
        accept     = in_valid && (state_reg == ST_IDLE);
        sel_count  = static_reg ? s_count_reg : d_count_reg;
        scan_count = scan_static_reg ? s_count_reg : d_count_reg;
        full       = sel_count >= CW'(MAX_BOXES);
        slot_bad   = 32'(idx_reg) >= 32'(sel_count);
        res_done   = stat.res_valid && (stat.res_hit || stat.res_last);
        to_dynamic = stat.res_valid && !stat.res_hit && stat.res_last
                     && scan_static_reg && (func_reg == FN_QUERY_ALL)
                     && (d_count_reg != '0);
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (func_reg inside {FN_ADD, FN_SET_POS})
                    state_next = ST_DONE;
                else if (s_count_reg != '0)
                    state_next = ST_SCAN;
                else if ((func_reg == FN_QUERY_ALL) && (d_count_reg != '0))
                    state_next = ST_SCAN;
                else
                    state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (res_done && !to_dynamic)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs to the datapath and the handshake
    always_comb
    begin
        in_stall        = (state_reg != ST_IDLE);
        cmd.load        = accept;
        cmd.wr_static   = static_reg;
        cmd.wr_pos      = (state_reg == ST_DECODE)
                          && (((func_reg == FN_ADD) && !full)
                              || ((func_reg == FN_SET_POS) && !slot_bad));
        cmd.wr_shape    = (state_reg == ST_DECODE) && (func_reg == FN_ADD) && !full;
        cmd.scan_valid  = (state_reg == ST_SCAN) && (issue_reg < scan_count) && !res_done;
        cmd.scan_static = scan_static_reg;
        cmd.scan_last   = (CW'(issue_reg + 1'b1) == scan_count);
        cmd.flush       = (state_reg == ST_SCAN) && stat.res_valid && stat.res_hit;
        wr_addr         = (func_reg == FN_ADD) ? AW'(sel_count) : AW'(idx_reg);
        rd_addr         = AW'(issue_reg);
    end

    // counters, pending result and output register
    always_comb
    begin
        s_count_next     = s_count_reg;
        d_count_next     = d_count_reg;
        issue_next       = issue_reg;
        scan_static_next = scan_static_reg;
        pend_hit_next    = pend_hit_reg;
        pend_static_next = pend_static_reg;
        pend_slot_next   = pend_slot_reg;
        pend_new_next    = pend_new_reg;
        pend_err_next    = pend_err_reg;
        out_valid_next   = out_valid_reg && out_stall;

        case (state_reg)
            ST_DECODE:
            begin
                issue_next       = '0;
                scan_static_next = (s_count_reg != '0);
                pend_hit_next    = 1'b0;
                pend_static_next = 1'b0;
                pend_slot_next   = '0;
                pend_new_next    = '0;
                pend_err_next    = ERR_NONE;
                if (func_reg == FN_ADD)
                begin
                    if (full)
                        pend_err_next = ERR_FULL;
                    else
                    begin
                        pend_new_next = SLOT_W'(sel_count);
                        if (static_reg)
                            s_count_next = CW'(s_count_reg + 1'b1);
                        else
                            d_count_next = CW'(d_count_reg + 1'b1);
                    end
                end
                else if ((func_reg == FN_SET_POS) && slot_bad)
                    pend_err_next = ERR_SLOT;
            end
            ST_SCAN:
            begin
                if (cmd.scan_valid)
                    issue_next = CW'(issue_reg + 1'b1);
                if (stat.res_valid && stat.res_hit)
                begin
                    pend_hit_next    = 1'b1;
                    pend_static_next = scan_static_reg;
                    pend_slot_next   = stat.res_slot;
                end
                if (to_dynamic)
                begin
                    scan_static_next = 1'b0;
                    issue_next       = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_count_reg   <= '0;
            d_count_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_count_reg   <= s_count_next;
            d_count_reg   <= d_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func_t'(func);
            static_reg <= is_static;
            idx_reg    <= entry_index;
        end
        issue_reg       <= issue_next;
        scan_static_reg <= scan_static_next;
        pend_hit_reg    <= pend_hit_next;
        pend_static_reg <= pend_static_next;
        pend_slot_reg   <= pend_slot_next;
        pend_new_reg    <= pend_new_next;
        pend_err_reg    <= pend_err_next;
        if (out_load)
        begin
            out_hit_reg    <= pend_hit_reg;
            out_static_reg <= pend_static_reg;
            out_slot_reg   <= pend_slot_reg;
            out_new_reg    <= pend_new_reg;
            out_err_reg    <= pend_err_reg;
        end
    end

    always_comb
    begin
        out_valid     = out_valid_reg;
        hit           = out_hit_reg;
        hit_is_static = out_static_reg;
        hit_slot      = out_slot_reg;
        new_slot      = out_new_reg;
        error         = out_err_reg;
    end

endmodule

// File: hdl/point_in_box_table_query_core.sv
`timescale 1ns / 1ps

// Point-in-box table query: two tables (static, dynamic) of 2D boxes in Q16.16.
// Input channel in_valid/in_stall carries one operation per transaction:
// add a box, rewrite an entry's position, or query a point (statics only, or
// statics then dynamics). Output channel out_valid/out_stall returns exactly
// one result transaction per input transaction, in order.
// Add and position rewrite go from acceptance through decode to the output
// register. A query walks the selected table one entry per cycle through a
// 4-stage read/subtract/compare pipeline: the static table first if it holds
// entries, then the dynamic table when both tables are searched and the
// statics miss. The scan stops at the first hit; a query against empty
// tables answers without a scan.
// Throughput: one operation at a time; in_stall stays high from acceptance
// until the result is placed in the output register.
// A result waiting under out_stall holds in the output register and the next
// transaction is still accepted; a following result waits until it is taken.
// Reset clears both counts, the FSM and out_valid; table contents are not
// cleared, only entries below the counts are ever read.
module point_in_box_table_query_core #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pibq_pkg::FUNC_W-1:0]         func,
    input  logic                                is_static,
    input  logic [pibq_pkg::SLOT_W-1:0]         entry_index,
    input  logic signed [pibq_pkg::COORD_W-1:0] pos_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] pos_y,
    input  logic signed [pibq_pkg::COORD_W-1:0] center_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] center_y,
    input  logic [pibq_pkg::SIZE_W-1:0]         size_x,
    input  logic [pibq_pkg::SIZE_W-1:0]         size_y,
    input  logic signed [pibq_pkg::COORD_W-1:0] point_x,
    input  logic signed [pibq_pkg::COORD_W-1:0] point_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                hit_is_static,
    output logic [pibq_pkg::SLOT_W-1:0]         hit_slot,
    output logic [pibq_pkg::SLOT_W-1:0]         new_slot,
    output logic [pibq_pkg::ERR_W-1:0]          error
);
    import pibq_pkg::*;

    // table address and fill-count widths
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    cmd_t          cmd;
    stat_t         stat;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // sequencing: counts, scan issue, result staging and output register
    pibq_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .is_static     (is_static),
        .entry_index   (entry_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .hit_is_static (hit_is_static),
        .hit_slot      (hit_slot),
        .new_slot      (new_slot),
        .error         (error),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .stat          (stat)
    );

    // box tables and the containment pipeline
    pibq_dpath #(
        .MAX_BOXES (MAX_BOXES),
        .AW        (AW)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .center_x (center_x),
        .center_y (center_y),
        .size_x   (size_x),
        .size_y   (size_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .stat     (stat)
    );

    // no scan is issued while the block is idle
    a_no_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.scan_valid)
        else $error("scan issued while idle");

    // table writes and scan reads never overlap
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_valid |-> !(cmd.wr_pos || cmd.wr_shape))
        else $error("table write during scan");

    // pipeline flush only on a reported hit
    a_flush_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> (stat.res_valid && stat.res_hit))
        else $error("flush without hit");

    // a new result appears only at the end of a busy period
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in progress");

endmodule

// File: dv/point_in_box_table_query_core_tb.sv
`timescale 1ns / 1ps

import pibq_pkg::*;

localparam int TABLE_DEPTH = 64;

// one input transaction, as seen on the input ports
typedef struct {
    func_t            fn;
    bit               is_static;
    bit [5:0]         entry_index;
    bit signed [31:0] pos_x;
    bit signed [31:0] pos_y;
    bit signed [31:0] center_x;
    bit signed [31:0] center_y;
    bit [30:0]        size_x;
    bit [30:0]        size_y;
    bit signed [31:0] point_x;
    bit signed [31:0] point_y;
} box_op_t;

// one output transaction
typedef struct {
    bit       hit;
    bit       hit_is_static;
    bit [5:0] hit_slot;
    bit [5:0] new_slot;
    err_t     error;
} query_result_t;

// one stored box, widened so the containment test cannot overflow
typedef struct {
    longint px;
    longint py;
    longint cx;
    longint cy;
    longint sx;
    longint sy;
} box_rec_t;

class box_query_scoreboard;
    // index 1 is the static table, index 0 the dynamic one
    box_rec_t      tab [2][TABLE_DEPTH];
    int unsigned   used [2];
    query_result_t due_outcomes [$];
    int unsigned   faults;
    int unsigned   seen;

    function bit axis_holds(longint p, longint at, longint off, longint span);
        longint twice_d;
        twice_d = 2 * (p - at - off);
        return (twice_d < span) && (twice_d > -span);
    endfunction

    // first box in insertion order whose open interior holds the point
    function int first_box(int lst, longint x, longint y);
        for (int i = 0; i < used[lst]; i++)
        begin
            if (axis_holds(x, tab[lst][i].px, tab[lst][i].cx, tab[lst][i].sx) &&
                axis_holds(y, tab[lst][i].py, tab[lst][i].cy, tab[lst][i].sy))
                return i;
        end
        return -1;
    endfunction

    function void note_op(box_op_t op);
        query_result_t r;
        int            lst;
        int            slot;
        r.hit           = 1'b0;
        r.hit_is_static = 1'b0;
        r.hit_slot      = '0;
        r.new_slot      = '0;
        r.error         = ERR_NONE;
        lst = op.is_static ? 1 : 0;
        case (op.fn)
            FN_ADD:
            begin
                if (used[lst] >= TABLE_DEPTH)
                begin
                    r.error = ERR_FULL;
                end
                else
                begin
                    tab[lst][used[lst]].px = longint'(op.pos_x);
                    tab[lst][used[lst]].py = longint'(op.pos_y);
                    tab[lst][used[lst]].cx = longint'(op.center_x);
                    tab[lst][used[lst]].cy = longint'(op.center_y);
                    tab[lst][used[lst]].sx = longint'(op.size_x);
                    tab[lst][used[lst]].sy = longint'(op.size_y);
                    r.new_slot = 6'(used[lst]);
                    used[lst]++;
                end
            end
            FN_SET_POS:
            begin
                if (op.entry_index >= used[lst])
                begin
                    r.error = ERR_SLOT;
                end
                else
                begin
                    tab[lst][op.entry_index].px = longint'(op.pos_x);
                    tab[lst][op.entry_index].py = longint'(op.pos_y);
                end
            end
            default:
            begin
                slot = first_box(1, longint'(op.point_x), longint'(op.point_y));
                if (slot >= 0)
                begin
                    r.hit           = 1'b1;
                    r.hit_is_static = 1'b1;
                    r.hit_slot      = 6'(slot);
                end
                else if (op.fn == FN_QUERY_ALL)
                begin
                    slot = first_box(0, longint'(op.point_x), longint'(op.point_y));
                    if (slot >= 0)
                    begin
                        r.hit      = 1'b1;
                        r.hit_slot = 6'(slot);
                    end
                end
            end
        endcase
        due_outcomes.insert(due_outcomes.size(), r);
    endfunction

    function void check_outcome(query_result_t got);
        query_result_t want;
        seen++;
        if (due_outcomes.size() == 0)
        begin
            faults++;
            if (faults <= 10)
                $display("result %0d arrived with nothing outstanding", seen);
            return;
        end
        want = due_outcomes.pop_front();
        if (got.hit != want.hit || got.hit_is_static != want.hit_is_static ||
            got.hit_slot != want.hit_slot || got.new_slot != want.new_slot ||
            got.error != want.error)
        begin
            faults++;
            if (faults <= 10)
                $display({"result %0d mismatch: expected hit=%0b st=%0b slot=%0d new=%0d ",
                          "err=%0d, got hit=%0b st=%0b slot=%0d new=%0d err=%0d"},
                         seen, want.hit, want.hit_is_static, want.hit_slot,
                         want.new_slot, want.error, got.hit, got.hit_is_static,
                         got.hit_slot, got.new_slot, got.error);
        end
    endfunction
endclass

module point_in_box_table_query_core_tb;

    // Run sizing. Even ~1750 transactions, all at the worst rate of a full
    // two-table query miss, sit well inside the watchdog.
    localparam int RANDOM_PER_PHASE = 570;
    localparam int HOLD_CYCLES      = 600;
    localparam int DRAIN_CYCLES     = 300;
    localparam int WATCHDOG_CYCLES  = 1_500_000;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func        = '0;
    logic                is_static   = 1'b0;
    logic [SLOT_W-1:0]   entry_index = '0;
    logic signed [31:0]  pos_x       = '0;
    logic signed [31:0]  pos_y       = '0;
    logic signed [31:0]  center_x    = '0;
    logic signed [31:0]  center_y    = '0;
    logic [SIZE_W-1:0]   size_x      = '0;
    logic [SIZE_W-1:0]   size_y      = '0;
    logic signed [31:0]  point_x     = '0;
    logic signed [31:0]  point_y     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic                hit;
    logic                hit_is_static;
    logic [SLOT_W-1:0]   hit_slot;
    logic [SLOT_W-1:0]   new_slot;
    logic [ERR_W-1:0]    error;

    // idle percentages: sender is only read by the driving process,
    // receiver is updated with NBAs so its sampling cannot race
    int unsigned         tx_idle_pct = 23;
    int unsigned         rx_idle_pct = 63;
    logic                hold_start  = 1'b0;
    logic                hold_on     = 1'b0;
    int unsigned         cycles      = 0;

    box_query_scoreboard sb;

    point_in_box_table_query_core DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stall per cycle, overridden by the long hold-off.
    always @(posedge clk)
        out_stall <= hold_on || ($urandom_range(99) < rx_idle_pct);

    // Long hold-off, counted here so the sender keeps offering transactions
    // and the block backs up into its input.
    initial
    begin
        wait (hold_start);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Input monitor: every accepted transaction updates the predicted tables
    // and queues its outcome.
    always @(posedge clk)
    begin
        box_op_t op;
        if (rst_n && in_valid && !in_stall)
        begin
            op.fn          = func_t'(func);
            op.is_static   = is_static;
            op.entry_index = entry_index;
            op.pos_x       = pos_x;
            op.pos_y       = pos_y;
            op.center_x    = center_x;
            op.center_y    = center_y;
            op.size_x      = size_x;
            op.size_y      = size_y;
            op.point_x     = point_x;
            op.point_y     = point_y;
            sb.note_op(op);
        end
    end

    // Output monitor: compare each accepted result with the oldest outcome.
    always @(posedge clk)
    begin
        query_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.hit           = hit;
            got.hit_is_static = hit_is_static;
            got.hit_slot      = hit_slot;
            got.new_slot      = new_slot;
            got.error         = err_t'(error);
            sb.check_outcome(got);
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int q16(int units);
        return units * 65536;
    endfunction

    // random value within +/- units, Q16.16
    function automatic bit signed [31:0] near(int units);
        return $signed($urandom_range(2 * units * 65536)) - units * 65536;
    endfunction

    // every field random; callers overwrite what the operation uses, so the
    // unused fields still toggle
    function automatic box_op_t scrambled_op();
        box_op_t op;
        op.fn          = func_t'($urandom_range(3));
        op.is_static   = $urandom_range(1);
        op.entry_index = 6'($urandom_range(63));
        op.pos_x       = $urandom();
        op.pos_y       = $urandom();
        op.center_x    = $urandom();
        op.center_y    = $urandom();
        op.size_x      = 31'($urandom());
        op.size_y      = 31'($urandom());
        op.point_x     = $urandom();
        op.point_y     = $urandom();
        return op;
    endfunction

    function automatic box_op_t random_op();
        box_op_t  op;
        box_rec_t b;
        int       lst;
        int       pick;
        longint   half_x;
        longint   half_y;
        longint   off_x;
        longint   off_y;
        op   = scrambled_op();
        pick = $urandom_range(99);
        // a slice of pure noise: any operation, any values
        if (pick < 8)
            return op;
        if (pick < 28)
        begin
            op.fn = FN_ADD;
            if ($urandom_range(19) != 0)
            begin
                op.pos_x    = near(100);
                op.pos_y    = near(100);
                op.center_x = near(5);
                op.center_y = near(5);
                op.size_x   = 31'($urandom_range(q16(40)));
                op.size_y   = 31'($urandom_range(q16(40)));
            end
            if ($urandom_range(29) == 0)
                op.size_x = '0;
        end
        else if (pick < 45)
        begin
            op.fn = FN_SET_POS;
            lst   = op.is_static ? 1 : 0;
            // mostly live slots; the rest may point past the count
            if (sb.used[lst] != 0 && $urandom_range(6) != 0)
                op.entry_index = 6'($urandom_range(sb.used[lst] - 1));
            if ($urandom_range(19) != 0)
            begin
                op.pos_x = near(100);
                op.pos_y = near(100);
            end
        end
        else
        begin
            op.fn = $urandom_range(1) ? FN_QUERY_ALL : FN_QUERY_S;
            lst   = $urandom_range(1);
            if (sb.used[lst] == 0)
                lst = 1 - lst;
            if (sb.used[lst] != 0 && $urandom_range(3) != 0)
            begin
                // aim at a stored box, edges included now and then
                b      = sb.tab[lst][$urandom_range(sb.used[lst] - 1)];
                half_x = b.sx / 2;
                half_y = b.sy / 2;
                off_x  = longint'($urandom_range(32'(2 * half_x))) - half_x;
                off_y  = longint'($urandom_range(32'(2 * half_y))) - half_y;
                if ($urandom_range(9) == 0)
                    off_x = $urandom_range(1) ? half_x : -half_x;
                if ($urandom_range(9) == 0)
                    off_y = $urandom_range(1) ? half_y : -half_y;
                op.point_x = 32'(b.px + b.cx + off_x);
                op.point_y = 32'(b.py + b.cy + off_y);
            end
            else
            begin
                op.point_x = near(120);
                op.point_y = near(120);
            end
        end
        return op;
    endfunction

    // Drive one transaction: optional idle cycles, then hold the payload
    // until it is taken.
    task automatic send_op(input box_op_t op);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func        <= op.fn;
        is_static   <= op.is_static;
        entry_index <= op.entry_index;
        pos_x       <= op.pos_x;
        pos_y       <= op.pos_y;
        center_x    <= op.center_x;
        center_y    <= op.center_y;
        size_x      <= op.size_x;
        size_y      <= op.size_y;
        point_x     <= op.point_x;
        point_y     <= op.point_y;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic add_box(input bit st, input int px, input int py, input int cx,
                           input int cy, input bit [30:0] sx, input bit [30:0] sy);
        box_op_t op;
        op           = scrambled_op();
        op.fn        = FN_ADD;
        op.is_static = st;
        op.pos_x     = px;
        op.pos_y     = py;
        op.center_x  = cx;
        op.center_y  = cy;
        op.size_x    = sx;
        op.size_y    = sy;
        send_op(op);
    endtask

    task automatic move_box(input bit st, input bit [5:0] idx, input int px,
                            input int py);
        box_op_t op;
        op             = scrambled_op();
        op.fn          = FN_SET_POS;
        op.is_static   = st;
        op.entry_index = idx;
        op.pos_x       = px;
        op.pos_y       = py;
        send_op(op);
    endtask

    task automatic query_at(input func_t f, input int x, input int y);
        box_op_t op;
        op         = scrambled_op();
        op.fn      = f;
        op.point_x = x;
        op.point_y = y;
        send_op(op);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty tables, edges, zero size, wide boxes ---
        // queries and rewrites against empty tables
        query_at(FN_QUERY_S, 32'sh8000_0000, 32'sh7FFF_FFFF);
        query_at(FN_QUERY_ALL, 32'sh7FFF_FFFF, 32'sh8000_0000);
        move_box(1'b1, 6'd0, q16(1), q16(1));
        move_box(1'b0, 6'd63, q16(1), q16(1));
        // static 0: centre (11,9), half size (2,3); static 1 same spot, no area
        add_box(1'b1, q16(10), q16(10), q16(1), q16(-1), 31'(q16(4)), 31'(q16(6)));
        add_box(1'b1, q16(10), q16(10), q16(1), q16(-1), '0, '0);
        add_box(1'b0, q16(-50), q16(20), 0, 0, 31'(q16(10)), 31'(q16(10)));
        // full-scale boxes: static 2 covers a huge area round -1, dynamic 1
        // sits beyond the top of the coordinate range
        add_box(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_box(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 31'h7FFF_FFFF);
        query_at(FN_QUERY_S, q16(11), q16(9));
        // on the right edge of static 0: falls through to the wide box
        query_at(FN_QUERY_S, q16(13), q16(9));
        query_at(FN_QUERY_ALL, q16(-50), q16(20));
        // park the wide static box out of reach
        move_box(1'b1, 6'd2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        query_at(FN_QUERY_ALL, q16(-50), q16(20));
        query_at(FN_QUERY_S, q16(-50), q16(20));
        query_at(FN_QUERY_S, q16(13), q16(9));
        query_at(FN_QUERY_S, q16(11) - 1, q16(12) - 1);
        // move static 0 away; the zero-size box left behind must not hit
        move_box(1'b1, 6'd0, q16(-200), q16(-200));
        query_at(FN_QUERY_S, q16(11), q16(9));
        move_box(1'b1, 6'd3, 0, 0);
        // bring dynamic 1 over the origin, probe it, then park it again
        move_box(1'b0, 6'd1, 32'sh8000_0000, 32'sh8000_0000);
        query_at(FN_QUERY_ALL, q16(500), q16(-500));
        query_at(FN_QUERY_ALL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        query_at(FN_QUERY_ALL, q16(-199), q16(-201));
        move_box(1'b0, 6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);

        // --- random: three idling profiles, long hold-off in the last ---
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 23;
                    rx_idle_pct <= 63;
                end
                1:
                begin
                    tx_idle_pct = 63;
                    rx_idle_pct <= 23;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    hold_start  <= 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_op(random_op());
        end
        in_valid <= 1'b0;

        while (sb.due_outcomes.size() != 0)
            @(posedge clk);
        // anything late or spurious shows up here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.faults == 0 && sb.due_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
